@@ hdl/wrp_pkg.sv @@
// Shared types, constants and helpers for the RIFF/WAVE header parser.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`default_nettype none

package wrp_pkg;

    localparam int POSITION_BITS_DEF = 40;
    localparam int DATA_OFFSET_BITS  = 40;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN      = 32'd16;
    localparam logic [3:0]  RIFF_HDR_END = 4'd11;
    localparam logic [3:0]  CHUNK_HDR_END = 4'd7;
    localparam logic [3:0]  FMT_BODY_END = 4'd15;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]                  status;
        logic [15:0]                 format_tag;
        logic [15:0]                 channel_count;
        logic [31:0]                 sample_rate;
        logic [31:0]                 byte_rate;
        logic [15:0]                 block_align;
        logic [15:0]                 sample_bits;
        logic [DATA_OFFSET_BITS-1:0] data_offset;
        logic [31:0]                 data_size;
    } t_result;

    // expected header byte; slots 4..7 (RIFF size) are not compared
    function automatic logic [7:0] hdr_magic(input logic [3:0] idx);
        logic [31:0] word;
        logic [7:0]  res;
        word = (idx < 4'd4) ? TAG_RIFF : TAG_WAVE;
        case (idx[1:0])
            2'd0:    res = word[7:0];
            2'd1:    res = word[15:8];
            2'd2:    res = word[23:16];
            default: res = word[31:24];
        endcase
        return res;
    endfunction

    function automatic logic [63:0] put_byte64(input logic [63:0] word,
                                               input logic [2:0]  sel,
                                               input logic [7:0]  b);
        logic [63:0] res;
        res = word;
        for (int k = 0; k < 8; k++) begin
            if (sel == 3'(k)) begin
                res[8*k +: 8] = b;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] put_byte32(input logic [31:0] word,
                                               input logic [1:0]  sel,
                                               input logic [7:0]  b);
        logic [31:0] res;
        res = word;
        for (int k = 0; k < 4; k++) begin
            if (sel == 2'(k)) begin
                res[8*k +: 8] = b;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/wav_riff_header_parser.sv @@
// Top level of the RIFF/WAVE header parser: input register, parse core, result register.
// Depends on wrp_pkg, wrp_in_stage, wrp_parse_core, wrp_out_stage.
//
// Usage:
//   Input channel: one file byte per item on i_data_byte, with i_first_byte marking
//   the start of a file and i_final_byte the last byte available. An item is taken
//   at a clock edge where i_in_valid is high and o_in_stall is low.
//   Output channel: at most one result per file (status plus format and data chunk
//   fields), presented on o_out_valid and taken when i_out_stall is low.
//   Throughput: one byte per cycle, sustained while the result register is not held under
//   i_out_stall, set by the state update in the parse core. A result is loaded into the
//   result register when the core takes the byte that completes it from the input register.
//   Stall: while a result is held under i_out_stall, the parse core does not advance;
//   the input register takes at most one byte and then o_in_stall rises.
//   Reset (i_rst_n low, synchronous): both registers empty, parse restarts at the
//   RIFF header; bytes without a first-byte mark are parsed as a new file.
//   After a result, bytes are ignored until the next first-byte mark.
`default_nettype none

module wav_riff_header_parser #(
    parameter int POSITION_BITS = wrp_pkg::POSITION_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_first_byte,
    input  wire         i_final_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_format_tag,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [31:0] o_byte_rate,
    output logic [15:0] o_block_align,
    output logic [15:0] o_sample_bits,
    output logic [wrp_pkg::DATA_OFFSET_BITS-1:0] o_data_offset,
    output logic [31:0] o_data_size
);

    wrp_pkg::t_item   w_in_item;
    wrp_pkg::t_item   w_s1_item;
    wrp_pkg::t_result w_core_result;
    wrp_pkg::t_result w_out_result;
    logic             w_s1_valid;
    logic             w_out_free;
    logic             w_advance;
    logic             w_emit;

    assign w_in_item.data_byte  = i_data_byte;
    assign w_in_item.first_byte = i_first_byte;
    assign w_in_item.final_byte = i_final_byte;
    assign w_advance            = w_s1_valid && w_out_free;

    wrp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_item    (w_s1_item)
    );

    wrp_parse_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_s1_item),
        .o_emit    (w_emit),
        .o_result  (w_core_result)
    );

    wrp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_emit),
        .i_result (w_core_result),
        .i_stall  (i_out_stall),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .o_result (w_out_result)
    );

    assign o_status        = w_out_result.status;
    assign o_format_tag    = w_out_result.format_tag;
    assign o_channel_count = w_out_result.channel_count;
    assign o_sample_rate   = w_out_result.sample_rate;
    assign o_byte_rate     = w_out_result.byte_rate;
    assign o_block_align   = w_out_result.block_align;
    assign o_sample_bits   = w_out_result.sample_bits;
    assign o_data_offset   = w_out_result.data_offset;
    assign o_data_size     = w_out_result.data_size;

endmodule

`default_nettype wire

@@ hdl/wrp_in_stage.sv @@
// Input register for the parser: holds one byte item until the core takes it.
// Depends on wrp_pkg (t_item).
`default_nettype none

module wrp_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wrp_pkg::t_item      i_item,
    input  wire                 i_advance,
    output logic                o_valid,
    output wrp_pkg::t_item      o_item
);

    logic           r_valid;
    logic           n_valid;
    wrp_pkg::t_item r_item;
    logic           w_accept;

    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/wrp_parse_core.sv @@
// Parse state and per-byte update: header check, chunk walk, fmt capture, skip.
// Depends on wrp_pkg (t_item, t_result, tags, status codes, byte helpers).
`default_nettype none

module wrp_parse_core #(
    parameter int POSITION_BITS = wrp_pkg::POSITION_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_advance,
    input  wrp_pkg::t_item      i_item,
    output logic                o_emit,
    output wrp_pkg::t_result    o_result
);

    typedef enum logic [4:0] {
        PH_RIFF  = 5'b00001,
        PH_CHUNK = 5'b00010,
        PH_FMT   = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_DONE  = 5'b10000
    } t_phase;

    t_phase                     r_phase,    n_phase;
    logic [3:0]                 r_idx,      n_idx;
    logic [POSITION_BITS-1:0]   r_pos,      n_pos;
    logic [32:0]                r_skip,     n_skip;
    logic                       r_fmt_seen, n_fmt_seen;
    logic                       r_data_seen, n_data_seen;
    logic [31:0]                r_tag,      n_tag;
    logic [31:0]                r_len,      n_len;
    logic [63:0]                r_short,    n_short;
    logic [63:0]                r_rates,    n_rates;
    logic [wrp_pkg::DATA_OFFSET_BITS-1:0] r_ofs, n_ofs;
    logic [31:0]                r_size,     n_size;

    logic [wrp_pkg::DATA_OFFSET_BITS-1:0] w_ofs_here;
    logic [POSITION_BITS-1:0]   w_pos_inc;

    t_phase                     c_phase;
    logic [3:0]                 c_idx;
    logic [POSITION_BITS-1:0]   c_pos;
    logic [32:0]                c_skip;
    logic                       c_fmt_seen;
    logic                       c_data_seen;
    logic [7:0]                 b;
    logic                       emitted;
    logic [1:0]                 status;
    logic [32:0]                skip_amt;
    logic [31:0]                fmt_rest;

    generate
        if (POSITION_BITS >= wrp_pkg::DATA_OFFSET_BITS) begin : g_ofs_trunc
            assign w_ofs_here = w_pos_inc[wrp_pkg::DATA_OFFSET_BITS-1:0];
        end else begin : g_ofs_ext
            assign w_ofs_here = {{(wrp_pkg::DATA_OFFSET_BITS-POSITION_BITS){1'b0}},
                                 w_pos_inc};
        end
    endgenerate

    always_comb begin
        b           = i_item.data_byte;
        c_phase     = i_item.first_byte ? PH_RIFF : r_phase;
        c_idx       = i_item.first_byte ? 4'd0 : r_idx;
        c_pos       = i_item.first_byte ? '0 : r_pos;
        c_skip      = i_item.first_byte ? 33'd0 : r_skip;
        c_fmt_seen  = i_item.first_byte ? 1'b0 : r_fmt_seen;
        c_data_seen = i_item.first_byte ? 1'b0 : r_data_seen;
        w_pos_inc   = c_pos + POSITION_BITS'(1);

        n_phase     = c_phase;
        n_idx       = c_idx;
        n_pos       = c_pos;
        n_skip      = c_skip;
        n_fmt_seen  = c_fmt_seen;
        n_data_seen = c_data_seen;
        n_tag       = r_tag;
        n_len       = r_len;
        n_short     = r_short;
        n_rates     = r_rates;
        n_ofs       = r_ofs;
        n_size      = r_size;
        emitted     = 1'b0;
        status      = wrp_pkg::ST_OK;
        skip_amt    = 33'd0;
        fmt_rest    = r_len - wrp_pkg::FMT_MIN;

        if (c_phase != PH_DONE) begin
            n_pos = w_pos_inc;
            case (c_phase)
                PH_RIFF: begin
                    if ((c_idx < 4'd4 || c_idx >= 4'd8) &&
                        b != wrp_pkg::hdr_magic(c_idx)) begin
                        emitted = 1'b1;
                        status  = wrp_pkg::ST_BAD_MAGIC;
                    end else if (c_idx == wrp_pkg::RIFF_HDR_END) begin
                        n_idx   = 4'd0;
                        n_phase = PH_CHUNK;
                    end else begin
                        n_idx = c_idx + 4'd1;
                    end
                end
                PH_CHUNK: begin
                    if (c_idx < 4'd4) begin
                        n_tag = wrp_pkg::put_byte32((c_idx == 4'd0) ? 32'd0 : r_tag,
                                                    c_idx[1:0], b);
                    end else begin
                        n_len = wrp_pkg::put_byte32((c_idx == 4'd4) ? 32'd0 : r_len,
                                                    c_idx[1:0], b);
                    end
                    skip_amt = {1'b0, n_len} + {32'd0, n_len[0]};
                    if (c_idx != wrp_pkg::CHUNK_HDR_END) begin
                        n_idx = c_idx + 4'd1;
                    end else if (r_tag == wrp_pkg::TAG_FMT &&
                                 n_len >= wrp_pkg::FMT_MIN) begin
                        n_idx   = 4'd0;
                        n_phase = PH_FMT;
                    end else begin
                        if (r_tag == wrp_pkg::TAG_DATA) begin
                            n_ofs       = w_ofs_here;
                            n_size      = n_len;
                            n_data_seen = 1'b1;
                        end
                        if (r_tag == wrp_pkg::TAG_DATA && c_fmt_seen) begin
                            emitted = 1'b1;
                            status  = (n_len == 32'd0) ? wrp_pkg::ST_EMPTY
                                                       : wrp_pkg::ST_OK;
                        end else begin
                            n_skip  = skip_amt;
                            n_idx   = 4'd0;
                            n_phase = (skip_amt == 33'd0) ? PH_CHUNK : PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    if (c_idx < 4'd4) begin
                        n_short = wrp_pkg::put_byte64(r_short, c_idx[2:0], b);
                    end else if (c_idx < 4'd12) begin
                        n_rates = wrp_pkg::put_byte64(r_rates, 3'(c_idx - 4'd4), b);
                    end else begin
                        n_short = wrp_pkg::put_byte64(r_short, 3'(c_idx - 4'd8), b);
                    end
                    skip_amt = {1'b0, fmt_rest} + {32'd0, r_len[0]};
                    if (c_idx != wrp_pkg::FMT_BODY_END) begin
                        n_idx = c_idx + 4'd1;
                    end else begin
                        n_fmt_seen = 1'b1;
                        if (c_data_seen) begin
                            emitted = 1'b1;
                            status  = (r_size == 32'd0) ? wrp_pkg::ST_EMPTY
                                                        : wrp_pkg::ST_OK;
                        end else begin
                            n_skip  = skip_amt;
                            n_idx   = 4'd0;
                            n_phase = (skip_amt == 33'd0) ? PH_CHUNK : PH_SKIP;
                        end
                    end
                end
                default: begin
                    n_skip = c_skip - 33'd1;
                    if (n_skip == 33'd0) begin
                        n_idx   = 4'd0;
                        n_phase = PH_CHUNK;
                    end
                end
            endcase
            if (!emitted && i_item.final_byte) begin
                emitted = 1'b1;
                status  = wrp_pkg::ST_TRUNCATED;
            end
            if (emitted) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_comb begin
        o_emit   = emitted;
        o_result = '0;
        o_result.status = status;
        if (status == wrp_pkg::ST_OK || status == wrp_pkg::ST_EMPTY) begin
            o_result.format_tag    = n_short[15:0];
            o_result.channel_count = n_short[31:16];
            o_result.sample_rate   = n_rates[31:0];
            o_result.byte_rate     = n_rates[63:32];
            o_result.block_align   = n_short[47:32];
            o_result.sample_bits   = n_short[63:48];
            o_result.data_offset   = n_ofs;
            o_result.data_size     = n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_idx       <= 4'd0;
            r_pos       <= '0;
            r_skip      <= 33'd0;
            r_fmt_seen  <= 1'b0;
            r_data_seen <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_pos       <= n_pos;
            r_skip      <= n_skip;
            r_fmt_seen  <= n_fmt_seen;
            r_data_seen <= n_data_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_short <= n_short;
            r_rates <= n_rates;
            r_ofs   <= n_ofs;
            r_size  <= n_size;
        end
    end

endmodule

`default_nettype wire

@@ hdl/wrp_out_stage.sv @@
// Result register: holds one parse result until the receiver takes it.
// Depends on wrp_pkg (t_result).
`default_nettype none

module wrp_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wrp_pkg::t_result    i_result,
    input  wire                 i_stall,
    output logic                o_free,
    output logic                o_valid,
    output wrp_pkg::t_result    o_result
);

    logic             r_valid;
    logic             n_valid;
    wrp_pkg::t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid && i_stall;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_wav_riff_header_parser.sv @@
// Testbench for wav_riff_header_parser: streams whole, broken and noisy WAV files one byte
// per item and checks each header result against a scoreboard that parses the same bytes.
// Depends on wrp_pkg and the RTL in hdl/; self-contained otherwise.
`timescale 1ns / 100ps

module tb_wav_riff_header_parser;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [4:0] {
        PH_RIFF  = 5'b00001,
        PH_CHUNK = 5'b00010,
        PH_FMT   = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_DONE  = 5'b10000
    } t_phase;
    typedef enum int {
        K_FMT_FIRST, K_DATA_FIRST, K_SHORT_FMT, K_REPEATED, K_BAD_MAGIC, K_TRUNCATED, K_NOISE
    } t_file_kind;

    class wav_header_scoreboard;
        wrp_pkg::t_result expected_headers[$];
        t_phase      phase;
        logic [3:0]  hdr_idx;
        logic [39:0] file_pos;
        logic [31:0] chunk_tag;
        logic [31:0] chunk_len;
        logic [32:0] skip_left;
        bit          fmt_seen;
        bit          data_seen;
        logic [63:0] short_fields;
        logic [63:0] rates;
        logic [39:0] data_offset;
        logic [31:0] data_size;
        int          n_checked;
        int          n_mismatches;
        int          n_status[4];

        function new();
            restart();
        endfunction

        function void restart();
            phase        = PH_RIFF;
            hdr_idx      = '0;
            file_pos     = '0;
            chunk_tag    = '0;
            chunk_len    = '0;
            skip_left    = '0;
            fmt_seen     = 1'b0;
            data_seen    = 1'b0;
            short_fields = '0;
            rates        = '0;
            data_offset  = '0;
            data_size    = '0;
        endfunction

        function void emit(logic [1:0] st);
            wrp_pkg::t_result r;
            r = '0;
            r.status = st;
            if (st == wrp_pkg::ST_OK || st == wrp_pkg::ST_EMPTY) begin
                r.format_tag    = short_fields[15:0];
                r.channel_count = short_fields[31:16];
                r.sample_rate   = rates[31:0];
                r.byte_rate     = rates[63:32];
                r.block_align   = short_fields[47:32];
                r.sample_bits   = short_fields[63:48];
                r.data_offset   = data_offset;
                r.data_size     = data_size;
            end
            expected_headers.insert(expected_headers.size(), r);
            phase = PH_DONE;
        endfunction

        function void start_skip(logic [32:0] amount);
            skip_left = amount;
            hdr_idx   = '0;
            phase     = (amount == 0) ? PH_CHUNK : PH_SKIP;
        endfunction

        // returns 1 when the byte is parsed, 0 when it is ignored
        function bit take_byte(logic [7:0] b, bit first, bit last);
            int          k;
            logic [39:0] here;
            logic [31:0] magic;
            if (first) restart();
            if (phase == PH_DONE) return 1'b0;
            here     = file_pos;
            file_pos = file_pos + 40'd1;
            k        = int'(hdr_idx);
            case (phase)
                PH_RIFF: begin
                    magic = (k < 4) ? wrp_pkg::TAG_RIFF : wrp_pkg::TAG_WAVE;
                    if ((k < 4 || k >= 8) && b != magic[8*(k%4) +: 8]) begin
                        emit(wrp_pkg::ST_BAD_MAGIC);
                        return 1'b1;
                    end
                    if (hdr_idx == wrp_pkg::RIFF_HDR_END) begin
                        hdr_idx = '0;
                        phase   = PH_CHUNK;
                    end else begin
                        hdr_idx = hdr_idx + 4'd1;
                    end
                end
                PH_CHUNK: begin
                    if (k == 0) begin
                        chunk_tag = '0;
                        chunk_len = '0;
                    end
                    if (k < 4) chunk_tag[8*k +: 8] = b;
                    else       chunk_len[8*(k-4) +: 8] = b;
                    if (hdr_idx != wrp_pkg::CHUNK_HDR_END) begin
                        hdr_idx = hdr_idx + 4'd1;
                    end else if (chunk_tag == wrp_pkg::TAG_FMT &&
                                 chunk_len >= wrp_pkg::FMT_MIN) begin
                        hdr_idx = '0;
                        phase   = PH_FMT;
                    end else begin
                        if (chunk_tag == wrp_pkg::TAG_DATA) begin
                            data_offset = here + 40'd1;
                            data_size   = chunk_len;
                            data_seen   = 1'b1;
                            if (fmt_seen) begin
                                emit((data_size == 0) ? wrp_pkg::ST_EMPTY : wrp_pkg::ST_OK);
                                return 1'b1;
                            end
                        end
                        start_skip({1'b0, chunk_len} + chunk_len[0]);
                    end
                end
                PH_FMT: begin
                    if (k < 4)       short_fields[8*k +: 8] = b;
                    else if (k < 12) rates[8*(k-4) +: 8] = b;
                    else             short_fields[8*(k-8) +: 8] = b;
                    if (hdr_idx != wrp_pkg::FMT_BODY_END) begin
                        hdr_idx = hdr_idx + 4'd1;
                    end else begin
                        fmt_seen = 1'b1;
                        if (data_seen) begin
                            emit((data_size == 0) ? wrp_pkg::ST_EMPTY : wrp_pkg::ST_OK);
                            return 1'b1;
                        end
                        start_skip({1'b0, chunk_len - wrp_pkg::FMT_MIN} + chunk_len[0]);
                    end
                end
                default: begin
                    skip_left = skip_left - 33'd1;
                    if (skip_left == 0) begin
                        hdr_idx = '0;
                        phase   = PH_CHUNK;
                    end
                end
            endcase
            if (last) emit(wrp_pkg::ST_TRUNCATED);
            return 1'b1;
        endfunction

        function void compare(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                n_mismatches++;
                if (n_mismatches <= 10)
                    $display("MISMATCH result %0d %s: expected %0h, got %0h",
                             n_checked, name, exp_v, got_v);
            end
        endfunction

        function void check_header(wrp_pkg::t_result got);
            wrp_pkg::t_result exp_r;
            n_checked++;
            if (expected_headers.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= 10)
                    $display("MISMATCH result %0d: none expected, got status %0d",
                             n_checked, got.status);
                return;
            end
            exp_r = expected_headers.pop_front();
            n_status[exp_r.status]++;
            compare("status",        exp_r.status,        got.status);
            compare("format_tag",    exp_r.format_tag,    got.format_tag);
            compare("channel_count", exp_r.channel_count, got.channel_count);
            compare("sample_rate",   exp_r.sample_rate,   got.sample_rate);
            compare("byte_rate",     exp_r.byte_rate,     got.byte_rate);
            compare("block_align",   exp_r.block_align,   got.block_align);
            compare("sample_bits",   exp_r.sample_bits,   got.sample_bits);
            compare("data_offset",   exp_r.data_offset,   got.data_offset);
            compare("data_size",     exp_r.data_size,     got.data_size);
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_data_byte  = '0;
    logic        i_first_byte = 1'b0;
    logic        i_final_byte = 1'b0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [15:0] o_format_tag;
    logic [15:0] o_channel_count;
    logic [31:0] o_sample_rate;
    logic [31:0] o_byte_rate;
    logic [15:0] o_block_align;
    logic [15:0] o_sample_bits;
    logic [wrp_pkg::DATA_OFFSET_BITS-1:0] o_data_offset;
    logic [31:0] o_data_size;
    wrp_pkg::t_result seen_header;

    wrp_pkg::t_item       byte_stream[$];
    wav_header_scoreboard scoreboard = new();
    wav_header_scoreboard planner    = new();
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   items_taken    = 0;
    int                   cycle_count    = 0;
    bit                   timed_out      = 1'b0;

    wav_riff_header_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_first_byte    (i_first_byte),
        .i_final_byte    (i_final_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_format_tag    (o_format_tag),
        .o_channel_count (o_channel_count),
        .o_sample_rate   (o_sample_rate),
        .o_byte_rate     (o_byte_rate),
        .o_block_align   (o_block_align),
        .o_sample_bits   (o_sample_bits),
        .o_data_offset   (o_data_offset),
        .o_data_size     (o_data_size)
    );

    assign seen_header = {o_status, o_format_tag, o_channel_count, o_sample_rate, o_byte_rate,
                          o_block_align, o_sample_bits, o_data_offset, o_data_size};

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            scoreboard.check_header(seen_header);
        end
    end

    function automatic void put(logic [7:0] b, bit first, bit last);
        wrp_pkg::t_item it;
        it.data_byte  = b;
        it.first_byte = first;
        it.final_byte = last;
        byte_stream.insert(byte_stream.size(), it);
    endfunction

    // little-endian, first-byte mark on the lowest byte only
    function automatic void put_le(logic [31:0] w, int n, bit mark);
        for (int k = 0; k < n; k++) put(w[8*k +: 8], mark && (k == 0), 1'b0);
    endfunction

    function automatic void put_body(int n);
        repeat (n) put(8'($urandom), 1'b0, 1'b0);
    endfunction

    function automatic void mark_last_final();
        wrp_pkg::t_item t;
        t = byte_stream[byte_stream.size() - 1];
        t.final_byte = 1'b1;
        byte_stream[byte_stream.size() - 1] = t;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void put_riff_head();
        put_le(wrp_pkg::TAG_RIFF, 4, 1'b1);
        put_le($urandom, 4, 1'b0);
        put_le(wrp_pkg::TAG_WAVE, 4, 1'b0);
    endfunction

    function automatic void put_chunk_head(logic [31:0] tag, logic [31:0] len);
        put_le(tag, 4, 1'b0);
        put_le(len, 4, 1'b0);
    endfunction

    function automatic void put_fmt();
        int len;
        len = $urandom_range(16, 23);
        put_chunk_head(wrp_pkg::TAG_FMT, len);
        put_le(pick_value(), 2, 1'b0);
        put_le(pick_value(), 2, 1'b0);
        put_le(pick_value(), 4, 1'b0);
        put_le(pick_value(), 4, 1'b0);
        put_le(pick_value(), 2, 1'b0);
        put_le(pick_value(), 2, 1'b0);
        put_body(len - 16 + len % 2);
    endfunction

    function automatic void put_small_chunk(logic [31:0] tag);
        int len;
        len = $urandom_range(0, 9);
        put_chunk_head(tag, len);
        put_body(len + len % 2);
    endfunction

    function automatic void put_file(t_file_kind kind);
        int             start;
        int             k;
        wrp_pkg::t_item t;
        start = byte_stream.size();
        case (kind)
            K_FMT_FIRST: begin
                put_riff_head();
                if ($urandom_range(1)) put_small_chunk($urandom);
                put_fmt();
                if ($urandom_range(1)) put_small_chunk($urandom);
                put_chunk_head(wrp_pkg::TAG_DATA, pick_value());
            end
            K_DATA_FIRST: begin
                put_riff_head();
                put_small_chunk(wrp_pkg::TAG_DATA);
                if ($urandom_range(1)) put_small_chunk($urandom);
                put_fmt();
            end
            K_SHORT_FMT: begin
                put_riff_head();
                k = $urandom_range(0, 15);
                put_chunk_head(wrp_pkg::TAG_FMT, k);
                put_body(k + k % 2);
                put_fmt();
                put_chunk_head(wrp_pkg::TAG_DATA, pick_value());
            end
            K_REPEATED: begin
                put_riff_head();
                if ($urandom_range(1)) begin
                    put_small_chunk(wrp_pkg::TAG_DATA);
                    put_small_chunk(wrp_pkg::TAG_DATA);
                    put_fmt();
                end else begin
                    put_fmt();
                    put_fmt();
                    put_chunk_head(wrp_pkg::TAG_DATA, pick_value());
                end
            end
            K_BAD_MAGIC: begin
                put_riff_head();
                k = $urandom_range(0, 7);
                if (k >= 4) k += 4;
                t = byte_stream[start + k];
                t.data_byte = t.data_byte ^ 8'($urandom_range(1, 255));
                byte_stream[start + k] = t;
            end
            K_TRUNCATED: begin
                put_file(t_file_kind'($urandom_range(K_FMT_FIRST, K_REPEATED)));
                k = $urandom_range(1, byte_stream.size() - start - 1);
                while (byte_stream.size() > start + k) void'(byte_stream.pop_back());
                if ($urandom_range(3) != 0) mark_last_final();
            end
            default: begin
                repeat ($urandom_range(1, 12))
                    put(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
            end
        endcase
        if (kind <= K_REPEATED) begin
            if ($urandom_range(3) == 0) mark_last_final();
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 4)) put(8'($urandom), 1'b0, 1'($urandom_range(1)));
        end
    endfunction

    function automatic t_file_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return K_FMT_FIRST;
        if (r < 45) return K_DATA_FIRST;
        if (r < 55) return K_SHORT_FMT;
        if (r < 65) return K_REPEATED;
        if (r < 75) return K_BAD_MAGIC;
        if (r < 90) return K_TRUNCATED;
        return K_NOISE;
    endfunction

    function automatic void build_stimulus();
        int parsed;
        int nfile;
        int next;
        // unmarked header right after reset, broken in the last WAVE byte
        put_le(wrp_pkg::TAG_RIFF, 4, 1'b0);
        put_le(32'h55AA_00FF, 4, 1'b0);
        put_le({~wrp_pkg::TAG_WAVE[31:24], wrp_pkg::TAG_WAVE[23:0]}, 4, 1'b0);
        put(8'h00, 1'b1, 1'b0);
        put(8'hFF, 1'b0, 1'b1);
        put(wrp_pkg::TAG_RIFF[7:0], 1'b1, 1'b1);
        foreach (byte_stream[n])
            void'(planner.take_byte(byte_stream[n].data_byte, byte_stream[n].first_byte,
                                    byte_stream[n].final_byte));
        parsed = 0;
        nfile  = 0;
        next   = byte_stream.size();
        while (parsed < RANDOM_ITEMS) begin
            put_file((nfile <= K_NOISE) ? t_file_kind'(nfile) : pick_kind());
            for (int n = next; n < byte_stream.size(); n++)
                parsed += planner.take_byte(byte_stream[n].data_byte,
                                            byte_stream[n].first_byte,
                                            byte_stream[n].final_byte);
            next = byte_stream.size();
            nfile++;
        end
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_stream();
        int total;
        total = byte_stream.size();
        for (int n = 0; n < total; n++) begin
            if (n < total / 3) begin
                send_idle_pct  = 22;
                recv_stall_pct = 61;
            end else if (n < 2 * total / 3) begin
                send_idle_pct  = 61;
                recv_stall_pct = 22;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_data_byte  <= byte_stream[n].data_byte;
            i_first_byte <= byte_stream[n].first_byte;
            i_final_byte <= byte_stream[n].final_byte;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            void'(scoreboard.take_byte(byte_stream[n].data_byte, byte_stream[n].first_byte,
                                       byte_stream[n].final_byte));
            items_taken++;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        build_stimulus();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                send_stream();
                while (scoreboard.expected_headers.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            begin
                wait (cycle_count >= CYCLE_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, scoreboard.expected_headers.size());
        end else begin
            $display("Streamed %0d bytes, checked %0d header results, %0d mismatches",
                     items_taken, scoreboard.n_checked, scoreboard.n_mismatches);
            $display("Status mix: ok %0d, bad magic %0d, truncated %0d, empty data %0d",
                     scoreboard.n_status[wrp_pkg::ST_OK],
                     scoreboard.n_status[wrp_pkg::ST_BAD_MAGIC],
                     scoreboard.n_status[wrp_pkg::ST_TRUNCATED],
                     scoreboard.n_status[wrp_pkg::ST_EMPTY]);
        end
        if (!timed_out && scoreboard.n_mismatches == 0 &&
            scoreboard.expected_headers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/wrp_pkg.sv
hdl/wrp_in_stage.sv
hdl/wrp_parse_core.sv
hdl/wrp_out_stage.sv
hdl/wav_riff_header_parser.sv
tb/tb_wav_riff_header_parser.sv
